>>> rtl/ksl_pkg.sv
// Shared types, constants and key code lookup for the key press classifier.
`default_nettype none

package ksl_pkg;

    localparam int unsigned NUM_KEYS = 4;
    localparam int unsigned KEY_W    = 2;
    localparam int unsigned CNT_W    = 8;
    localparam int unsigned CODE_W   = 4;

    localparam logic [CNT_W-1:0] IDLE_COUNT = 8'hFF;
    localparam logic [CNT_W-1:0] LONG_RESET = 8'd20;
    localparam logic [CNT_W-1:0] SHORT_RESET = 8'd20;

    // Configuration register indexes
    localparam logic REG_LONG_TICKS  = 1'b0;
    localparam logic REG_SHORT_LIMIT = 1'b1;

    // Input mode codes
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_KEY  = 1'b1;

    // Result kinds
    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_LONG  = 1'b1;

    // Key identifiers
    localparam logic [KEY_W-1:0] KEY_ACK  = 2'd0;
    localparam logic [KEY_W-1:0] KEY_UP   = 2'd1;
    localparam logic [KEY_W-1:0] KEY_DN   = 2'd2;
    localparam logic [KEY_W-1:0] KEY_NAK  = 2'd3;

    // Key codes reported to the host
    localparam logic [CODE_W-1:0] CODE_ACK  = 4'hF;
    localparam logic [CODE_W-1:0] CODE_UP   = 4'hD;
    localparam logic [CODE_W-1:0] CODE_DOWN = 4'hC;
    localparam logic [CODE_W-1:0] CODE_NAK  = 4'hE;

    // Result slot carried down the cell row
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic              kind;
    } t_slot;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic             load;
        logic             shift;
        logic             tick;
        logic [KEY_W-1:0] key;
        logic             pressed;
        logic             link;
        logic [CNT_W-1:0] long_ticks;
        logic [CNT_W-1:0] short_limit;
    } t_cell_ctrl;

    function automatic logic [CODE_W-1:0] key_code(input logic [KEY_W-1:0] key);
        logic [CODE_W-1:0] code;
        case (key)
            KEY_ACK:  code = CODE_ACK;
            KEY_UP:   code = CODE_UP;
            KEY_DN:   code = CODE_DOWN;
            KEY_NAK:  code = CODE_NAK;
            default:  code = CODE_ACK;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ksl_cell.sv
// One key cell: hold counter, press classification and one result slot of the drain row.
`default_nettype none

module ksl_cell (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire [ksl_pkg::KEY_W-1:0]      i_key_id,
    input  wire ksl_pkg::t_cell_ctrl      i_ctrl,
    input  wire ksl_pkg::t_slot           i_slot_up,
    input  wire                           i_any_up,
    output ksl_pkg::t_slot                o_slot,
    output logic                          o_any
);

    logic [ksl_pkg::CNT_W-1:0] r_cnt;
    logic [ksl_pkg::CNT_W-1:0] n_cnt;
    ksl_pkg::t_slot            r_slot;
    ksl_pkg::t_slot            n_slot;
    logic                      hit;
    logic                      fire;

    assign hit = !i_ctrl.tick && (i_ctrl.key == i_key_id);

    // Update the counter on a request and load or shift the result slot
    always_comb begin
        n_cnt  = r_cnt;
        n_slot = r_slot;
        fire   = 1'b0;
        if (i_ctrl.load) begin
            if (i_ctrl.tick) begin
                if (i_ctrl.link && (r_cnt < i_ctrl.long_ticks)) begin
                    n_cnt = r_cnt + 8'd1;
                    fire  = ((r_cnt + 8'd1) == i_ctrl.long_ticks);
                end
            end else if (hit) begin
                if (i_ctrl.pressed) begin
                    n_cnt = '0;
                end else begin
                    fire  = i_ctrl.link && (r_cnt < i_ctrl.short_limit);
                    n_cnt = ksl_pkg::IDLE_COUNT;
                end
            end
            n_slot.valid = fire;
            n_slot.code  = ksl_pkg::key_code(i_key_id);
            n_slot.kind  = i_ctrl.tick ? ksl_pkg::KIND_LONG : ksl_pkg::KIND_SHORT;
        end else if (i_ctrl.shift) begin
            n_slot = i_slot_up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= ksl_pkg::IDLE_COUNT;
            r_slot.valid <= 1'b0;
        end else begin
            r_cnt        <= n_cnt;
            r_slot.valid <= n_slot.valid;
        end
        r_slot.code <= n_slot.code;
        r_slot.kind <= n_slot.kind;
    end

    // Pass slot down and flag any pending result here or above
    assign o_slot = r_slot;
    assign o_any  = r_slot.valid | i_any_up;

endmodule

`default_nettype wire

>>> rtl/key_short_long_press_classifier.sv
// Top level: configuration, request sequencer and the row of four key cells.
//
// Usage: requests arrive on i_valid/o_ready with i_mode, i_key_index, i_pressed
// and i_link_on. A request is either a 100 ms tick (i_mode = 0) or a press or
// release edge of one key. Results leave on o_valid/i_ready with o_key_code,
// o_press_kind and o_last; o_last marks the final result of a request.
// Each request is taken by all four cells at once. Results are then shifted
// out of the cell row toward cell 0, one slot per cycle while the row is not
// held; an empty slot at the head is skipped without waiting for the
// receiver, so results leave in key order, key 0 first. A request that
// yields no result holds o_ready low for one cycle. One request is in work
// at a time: o_ready stays low until the last result is taken.
// The drain row holds while i_ready is low and a result is shown.
// Reset (synchronous, active low) sets every hold counter idle (255), both
// thresholds to 20 ticks and clears all pending results. Registers are
// written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must write them
// only while the block is idle, as the block itself does not enforce it.
`default_nettype none

module key_short_long_press_classifier (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire                              i_cfg_idx,
    input  wire [ksl_pkg::CNT_W-1:0]         i_cfg_data,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire                              i_mode,
    input  wire [ksl_pkg::KEY_W-1:0]         i_key_index,
    input  wire                              i_pressed,
    input  wire                              i_link_on,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic [ksl_pkg::CODE_W-1:0]       o_key_code,
    output logic                             o_press_kind,
    output logic                             o_last
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    logic [ksl_pkg::CNT_W-1:0] r_long_ticks;
    logic [ksl_pkg::CNT_W-1:0] r_short_limit;
    ksl_pkg::t_cell_ctrl       ctrl;
    ksl_pkg::t_slot            slot_row [0:ksl_pkg::NUM_KEYS];
    logic                      any_row  [0:ksl_pkg::NUM_KEYS];
    logic                      accept;
    logic                      advance;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks  <= ksl_pkg::LONG_RESET;
            r_short_limit <= ksl_pkg::SHORT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ksl_pkg::REG_LONG_TICKS:  r_long_ticks  <= i_cfg_data;
                ksl_pkg::REG_SHORT_LIMIT: r_short_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;
    assign advance = (r_state == ST_DRAIN) && (!slot_row[0].valid || i_ready);

    // Broadcast control to the cells
    always_comb begin
        ctrl.load        = accept;
        ctrl.shift       = advance;
        ctrl.tick        = (i_mode == ksl_pkg::MODE_TICK);
        ctrl.key         = i_key_index;
        ctrl.pressed     = i_pressed;
        ctrl.link        = i_link_on;
        ctrl.long_ticks  = r_long_ticks;
        ctrl.short_limit = r_short_limit;
    end

    // Row end feeds empty slots
    assign slot_row[ksl_pkg::NUM_KEYS] = '0;
    assign any_row[ksl_pkg::NUM_KEYS]  = 1'b0;

    for (genvar g = 0; g < ksl_pkg::NUM_KEYS; g++) begin : g_cell
        ksl_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_key_id  (ksl_pkg::KEY_W'(g)),
            .i_ctrl    (ctrl),
            .i_slot_up (slot_row[g+1]),
            .i_any_up  (any_row[g+1]),
            .o_slot    (slot_row[g]),
            .o_any     (any_row[g])
        );
    end

    // Sequence: take a request, then drain until no slot is pending
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!any_row[0] || (advance && !any_row[1])) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Present the head slot
    assign o_valid      = (r_state == ST_DRAIN) && slot_row[0].valid;
    assign o_key_code   = slot_row[0].code;
    assign o_press_kind = slot_row[0].kind;
    assign o_last       = !any_row[1];

`ifndef SYNTH
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !any_row[0])
        else $error("pending result while idle");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> (r_state == ST_IDLE))
        else $error("drain continues after last result");

    a_tick_off_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_mode == ksl_pkg::MODE_TICK) && !i_link_on) |=> !o_valid)
        else $error("result from tick with link off");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_key_code >= ksl_pkg::CODE_DOWN))
        else $error("key code out of range");

    a_long_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_mode == ksl_pkg::MODE_KEY)) |=> (!o_valid || o_last))
        else $error("edge produced more than one result");
`endif

endmodule

`default_nettype wire

>>> sim/press_report_checker.sv
// Checker for the key press classifier: tracks hold counters and compares press reports.
module press_report_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [ksl_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic                       i_valid,
    input  logic                       i_ready_in,
    input  logic                       i_mode,
    input  logic [ksl_pkg::KEY_W-1:0]  i_key_index,
    input  logic                       i_pressed,
    input  logic                       i_link_on,
    input  logic                       i_valid_out,
    input  logic                       i_ready,
    input  logic [ksl_pkg::CODE_W-1:0] i_key_code,
    input  logic                       i_press_kind,
    input  logic                       i_last,
    output int                         o_mismatches,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ksl_pkg::CODE_W-1:0] code;
        logic                       kind;
        logic                       last;
    } t_press_report;

    t_press_report             expected_reports[$];
    logic [ksl_pkg::CNT_W-1:0] hold_count [ksl_pkg::NUM_KEYS];
    logic [ksl_pkg::CNT_W-1:0] long_ticks;
    logic [ksl_pkg::CNT_W-1:0] short_limit;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic logic [ksl_pkg::CODE_W-1:0] code_of(
        input logic [ksl_pkg::KEY_W-1:0] key);
        case (key)
            ksl_pkg::KEY_ACK:  return ksl_pkg::CODE_ACK;
            ksl_pkg::KEY_UP:   return ksl_pkg::CODE_UP;
            ksl_pkg::KEY_DN:   return ksl_pkg::CODE_DOWN;
            default:           return ksl_pkg::CODE_NAK;
        endcase
    endfunction

    // Advance the hold counters for one request and queue the reports it causes
    function automatic void classify_request(input logic mode,
                                             input logic [ksl_pkg::KEY_W-1:0] key,
                                             input logic pressed, input logic link);
        t_press_report found [ksl_pkg::NUM_KEYS];
        int            n;
        n = 0;
        if (mode == ksl_pkg::MODE_TICK) begin
            if (link) begin
                // scan in key order so simultaneous long presses come out ack first
                for (int k = 0; k < ksl_pkg::NUM_KEYS; k++) begin
                    if (hold_count[k] < long_ticks) begin
                        hold_count[k] = hold_count[k] + 8'd1;
                        if (hold_count[k] >= long_ticks) begin
                            found[n].code = code_of(ksl_pkg::KEY_W'(k));
                            found[n].kind = ksl_pkg::KIND_LONG;
                            found[n].last = 1'b0;
                            n++;
                        end
                    end
                end
            end
        end else if (pressed) begin
            hold_count[key] = '0;
        end else begin
            // a release with the link off still idles the counter
            if (link && hold_count[key] < short_limit) begin
                found[n].code = code_of(key);
                found[n].kind = ksl_pkg::KIND_SHORT;
                found[n].last = 1'b0;
                n++;
            end
            hold_count[key] = ksl_pkg::IDLE_COUNT;
        end
        for (int i = 0; i < n; i++) begin
            found[i].last = (i == n - 1);
            expected_reports.push_back(found[i]);
        end
    endfunction

    // Compare each taken report with the oldest expectation, then model new requests
    always @(posedge i_clk) begin : watch
        t_press_report want;
        if (!i_rst_n) begin
            for (int k = 0; k < ksl_pkg::NUM_KEYS; k++) hold_count[k] = ksl_pkg::IDLE_COUNT;
            long_ticks  = ksl_pkg::LONG_RESET;
            short_limit = ksl_pkg::SHORT_RESET;
            expected_reports.delete();
        end else begin
            if (i_valid_out && i_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected report: code %h kind %b last %b",
                             $time, i_key_code, i_press_kind, i_last);
                    o_mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    if (i_key_code !== want.code) begin
                        $display("%0t: key code mismatch: expected %h, got %h",
                                 $time, want.code, i_key_code);
                        o_mismatches++;
                    end
                    if (i_press_kind !== want.kind) begin
                        $display("%0t: press kind mismatch: expected %b, got %b",
                                 $time, want.kind, i_press_kind);
                        o_mismatches++;
                    end
                    if (i_last !== want.last) begin
                        $display("%0t: last flag mismatch: expected %b, got %b",
                                 $time, want.last, i_last);
                        o_mismatches++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ksl_pkg::REG_LONG_TICKS:  long_ticks  = i_cfg_data;
                    ksl_pkg::REG_SHORT_LIMIT: short_limit = i_cfg_data;
                    default:                  short_limit = i_cfg_data;
                endcase
            end
            if (i_valid && i_ready_in)
                classify_request(i_mode, i_key_index, i_pressed, i_link_on);
        end
        o_pending = expected_reports.size();
    end

endmodule

>>> sim/tb_top.sv
// Testbench top for the key press classifier: clock, reset, request stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 16;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic                       i_cfg_idx   = ksl_pkg::REG_LONG_TICKS;
    logic [ksl_pkg::CNT_W-1:0]  i_cfg_data  = '0;
    logic                       i_valid     = 1'b0;
    logic                       i_mode      = ksl_pkg::MODE_TICK;
    logic [ksl_pkg::KEY_W-1:0]  i_key_index = ksl_pkg::KEY_ACK;
    logic                       i_pressed   = 1'b0;
    logic                       i_link_on   = 1'b0;
    logic                       i_ready     = 1'b0;
    logic                       o_ready;
    logic                       o_valid;
    logic [ksl_pkg::CODE_W-1:0] o_key_code;
    logic                       o_press_kind;
    logic                       o_last;

    int   mismatch_count;
    int   pending_reports;
    int   cycle_count   = 0;
    bit   quiet         = 1'b0;
    int   send_idle_pct = 0;
    int   sent_count    = 0;
    logic key_held [ksl_pkg::NUM_KEYS];

    key_short_long_press_classifier i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_key_index  (i_key_index),
        .i_pressed    (i_pressed),
        .i_link_on    (i_link_on),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_key_code   (o_key_code),
        .o_press_kind (o_press_kind),
        .o_last       (o_last)
    );

    press_report_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .i_ready_in   (o_ready),
        .i_mode       (i_mode),
        .i_key_index  (i_key_index),
        .i_pressed    (i_pressed),
        .i_link_on    (i_link_on),
        .i_valid_out  (o_valid),
        .i_ready      (i_ready),
        .i_key_code   (o_key_code),
        .i_press_kind (o_press_kind),
        .i_last       (o_last),
        .o_mismatches (mismatch_count),
        .o_pending    (pending_reports)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Drive the report side: random stall bursts, calm stretches and one long hold-off
    initial begin : report_sink
        int stall_left;
        int stall_pct;
        int taken;
        int hold_left;
        int span;
        bit held_off;
        stall_left = 0;
        stall_pct  = 0;
        taken      = 0;
        hold_left  = 0;
        span       = 0;
        held_off   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) taken++;
            span++;
            if (span % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 15;
                    default: stall_pct = 40;
                endcase
            end
            // hold off long enough that the sender backs up behind a full block
            if (!held_off && taken >= 20) begin
                held_off  = 1'b1;
                hold_left = 120;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (quiet) begin
                i_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 8);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Offer one request and hold it until taken; returns at the accepting edge
    task automatic send_request(input logic mode, input logic [ksl_pkg::KEY_W-1:0] key,
                                input logic pressed, input logic link);
        if (sent_count % 16 == 0) begin
            case ($urandom_range(0, 2))
                0:       send_idle_pct = 0;
                1:       send_idle_pct = 20;
                default: send_idle_pct = 50;
            endcase
        end
        sent_count++;
        if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_mode      <= mode;
        i_key_index <= key;
        i_pressed   <= pressed;
        i_link_on   <= link;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Drop valid and wait until every expected report is out and the block is idle
    task automatic wait_until_settled();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_reports != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both thresholds on consecutive edges
    task automatic write_thresholds(input logic [ksl_pkg::CNT_W-1:0] long_ticks,
                                    input logic [ksl_pkg::CNT_W-1:0] short_limit);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= ksl_pkg::REG_LONG_TICKS;
        i_cfg_data <= long_ticks;
        @(posedge i_clk);
        i_cfg_idx  <= ksl_pkg::REG_SHORT_LIMIT;
        i_cfg_data <= short_limit;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin : stimulus
        int                        phase;
        int                        counted;
        int                        r;
        logic [ksl_pkg::KEY_W-1:0] k;
        logic                      p;
        logic                      m;
        logic                      lk;
        for (int i = 0; i < ksl_pkg::NUM_KEYS; i++) key_held[i] = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset thresholds: release without press, ignored ticks, short presses
        send_request(ksl_pkg::MODE_KEY,  ksl_pkg::KEY_ACK, 1'b0, 1'b1);
        send_request(ksl_pkg::MODE_TICK, ksl_pkg::KEY_NAK, 1'b1, 1'b0);
        send_request(ksl_pkg::MODE_KEY,  ksl_pkg::KEY_ACK, 1'b1, 1'b1);
        send_request(ksl_pkg::MODE_KEY,  ksl_pkg::KEY_UP,  1'b1, 1'b0);
        send_request(ksl_pkg::MODE_KEY,  ksl_pkg::KEY_DN,  1'b1, 1'b1);
        send_request(ksl_pkg::MODE_KEY,  ksl_pkg::KEY_NAK, 1'b1, 1'b1);
        send_request(ksl_pkg::MODE_TICK, ksl_pkg::KEY_NAK, 1'b1, 1'b1);
        send_request(ksl_pkg::MODE_KEY,  ksl_pkg::KEY_UP,  1'b0, 1'b1);
        send_request(ksl_pkg::MODE_KEY,  ksl_pkg::KEY_DN,  1'b0, 1'b0);
        send_request(ksl_pkg::MODE_TICK, ksl_pkg::KEY_ACK, 1'b0, 1'b0);
        send_request(ksl_pkg::MODE_KEY,  ksl_pkg::KEY_NAK, 1'b0, 1'b1);
        send_request(ksl_pkg::MODE_KEY,  ksl_pkg::KEY_ACK, 1'b0, 1'b1);

        // Four keys reach the long threshold on one tick, then stay held past it
        wait_until_settled();
        write_thresholds(8'd2, 8'd3);
        send_request(ksl_pkg::MODE_KEY,  ksl_pkg::KEY_ACK, 1'b1, 1'b1);
        send_request(ksl_pkg::MODE_KEY,  ksl_pkg::KEY_UP,  1'b1, 1'b1);
        send_request(ksl_pkg::MODE_KEY,  ksl_pkg::KEY_DN,  1'b1, 1'b1);
        send_request(ksl_pkg::MODE_KEY,  ksl_pkg::KEY_NAK, 1'b1, 1'b1);
        send_request(ksl_pkg::MODE_TICK, ksl_pkg::KEY_UP,  1'b0, 1'b1);
        send_request(ksl_pkg::MODE_TICK, ksl_pkg::KEY_DN,  1'b1, 1'b1);
        send_request(ksl_pkg::MODE_TICK, ksl_pkg::KEY_ACK, 1'b0, 1'b1);
        send_request(ksl_pkg::MODE_KEY,  ksl_pkg::KEY_ACK, 1'b0, 1'b1);
        send_request(ksl_pkg::MODE_KEY,  ksl_pkg::KEY_UP,  1'b0, 1'b0);
        send_request(ksl_pkg::MODE_KEY,  ksl_pkg::KEY_NAK, 1'b0, 1'b1);

        // Extreme thresholds: both reports for one hold, then a quick short press and a hold with neither
        wait_until_settled();
        write_thresholds(8'd1, 8'd254);
        send_request(ksl_pkg::MODE_KEY,  ksl_pkg::KEY_DN,  1'b1, 1'b1);
        send_request(ksl_pkg::MODE_TICK, ksl_pkg::KEY_ACK, 1'b0, 1'b1);
        send_request(ksl_pkg::MODE_KEY,  ksl_pkg::KEY_DN,  1'b0, 1'b1);
        wait_until_settled();
        write_thresholds(8'd254, 8'd1);
        send_request(ksl_pkg::MODE_KEY,  ksl_pkg::KEY_ACK, 1'b1, 1'b1);
        send_request(ksl_pkg::MODE_KEY,  ksl_pkg::KEY_ACK, 1'b0, 1'b1);
        send_request(ksl_pkg::MODE_KEY,  ksl_pkg::KEY_NAK, 1'b1, 1'b1);
        send_request(ksl_pkg::MODE_TICK, ksl_pkg::KEY_ACK, 1'b0, 1'b1);
        send_request(ksl_pkg::MODE_KEY,  ksl_pkg::KEY_NAK, 1'b0, 1'b1);

        // Random phases: mostly press/tick/release sequences, some noise
        for (phase = 0; phase < 5; phase++) begin
            wait_until_settled();
            case (phase)
                0:       write_thresholds(8'd3, 8'd5);
                1:       write_thresholds(8'd1, 8'd1);
                default: write_thresholds(8'($urandom_range(1, 6)), 8'($urandom_range(1, 8)));
            endcase
            quiet   = (phase == 4);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                r  = $urandom_range(0, 99);
                k  = ksl_pkg::KEY_W'($urandom_range(0, 3));
                p  = 1'($urandom_range(0, 1));
                m  = 1'($urandom_range(0, 1));
                lk = 1'($urandom_range(0, 1));
                if (r < 40) begin
                    send_request(ksl_pkg::MODE_TICK, k, p, 1'b1);
                    counted++;
                end else if (r < 85) begin
                    // mostly alternate press and release per key
                    p = key_held[k] ? ($urandom_range(0, 4) == 0) : ($urandom_range(0, 4) != 0);
                    key_held[k] = p;
                    send_request(ksl_pkg::MODE_KEY, k, p, $urandom_range(0, 9) != 0);
                    counted++;
                end else begin
                    if (m == ksl_pkg::MODE_KEY) key_held[k] = p;
                    send_request(m, k, p, lk);
                    if (m == ksl_pkg::MODE_KEY || lk) counted++;
                end
            end
        end

        wait_until_settled();
        if (mismatch_count == 0 && pending_reports == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
